// ----- rtl/pnd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pnd_pkg;

   // width of the remaining character count of a name
   localparam int unsigned CHARS_W = 13;

   // header constants
   localparam logic [7:0]  SHORT_MIN  = 8'h40;
   localparam logic [16:0] WIDE_BIAS  = 17'h07FBF;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_EMPTY     = 3'd1,
      ERR_SIX_LONG  = 3'd2,
      ERR_OVERRUN   = 3'd3,
      ERR_WIDE_LONG = 3'd4,
      ERR_BAD_LEN   = 3'd5
   } err_type;

   // six-bit code to ascii: digits, colon, upper case, underscore, lower case
   function automatic logic [7:0] sym_char(input logic [5:0] code);
      logic [7:0] c;
      c = 8'h00;
      case (code) inside
         [6'd0:6'd9]:   c = 8'h30 + {2'b00, code};
         6'd10:         c = 8'h3A;
         [6'd11:6'd36]: c = 8'h41 + ({2'b00, code} - 8'd11);
         6'd37:         c = 8'h5F;
         default:       c = 8'h61 + ({2'b00, code} - 8'd38);
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/pnd_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface pnd_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  byte_value;
   logic [15:0] remaining_bytes;

   modport source (output valid, output byte_value, output remaining_bytes, input ready);
   modport sink   (input valid, input byte_value, input remaining_bytes, output ready);
endinterface

`default_nettype wire

// ----- rtl/pnd_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface pnd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] char_count;
   logic [7:0] first_char;
   logic [7:0] second_char;
   logic       name_done;
   logic [2:0] error_code;

   modport source (output valid, output char_count, output first_char, output second_char,
                   output name_done, output error_code, input ready);
   modport sink   (input valid, input char_count, input first_char, input second_char,
                   input name_done, input error_code, output ready);
endinterface

`default_nettype wire

// ----- rtl/packed_name_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none

// path: an accepted request transaction passes through the input register, then the decode
//   logic feeding the response register
// throughput: one byte per cycle while the response side takes each response; the name state updates once per byte
// reset: synchronous, active high; clears the name state to "awaiting header",
//   empties both registers and sets byte_mode_ff back to six-bit names
module packed_name_decoder
   import pnd_pkg::*;
#(
   parameter int unsigned MAX_SIXBIT_CHARS = 36,
   parameter int unsigned MAX_LONG_CHARS   = 4096
) (
   input  wire logic   clock,
   input  wire logic   reset,
   pnd_req_if.sink     req_bus,
   pnd_rsp_if.source   rsp_bus,
   input  wire logic   csr_write_en,
   input  wire logic   csr_write_data
);

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_WIDE2  = 2'd1,
      PH_SIXBIT = 2'd2,
      PH_RAW    = 2'd3
   } phase_type;

   // configuration
   logic byte_mode_ff;

   // input register
   logic        s1_valid_ff;
   logic [7:0]  s1_byte_ff;
   logic [15:0] s1_rem_ff;

   // name state
   phase_type          phase_ff,   phase_in;
   logic [CHARS_W-1:0] chars_ff,   chars_in;
   logic [5:0]         residue_ff, residue_in;
   logic [2:0]         rcount_ff,  rcount_in;
   logic [7:0]         lead_ff,    lead_in;

   // response register
   logic       out_valid_ff;
   logic [1:0] out_cnt_ff,  out_cnt_in;
   logic [7:0] out_c0_ff,   out_c0_in;
   logic [7:0] out_c1_ff,   out_c1_in;
   logic       out_done_ff, out_done_in;
   err_type    out_err_ff,  out_err_in;

   // handshake: the response register moves when empty or taken, the input
   // register when empty or when its byte moves on into the response register
   logic out_adv;
   logic s1_fire;
   logic req_take;

   assign out_adv  = !out_valid_ff || rsp_bus.ready;
   assign s1_fire  = s1_valid_ff && out_adv;
   assign req_take = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !s1_valid_ff || out_adv;

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.char_count  = out_cnt_ff;
   assign rsp_bus.first_char  = out_c0_ff;
   assign rsp_bus.second_char = out_c1_ff;
   assign rsp_bus.name_done   = out_done_ff;
   assign rsp_bus.error_code  = out_err_ff;

   // header arithmetic
   logic [16:0] rem_ext;
   logic [10:0] six_bits;
   logic [16:0] need_six;     // length byte plus packed payload bytes
   logic [16:0] need_short;   // length byte plus raw bytes
   logic [16:0] wide_len;     // bit 16 set when the two-byte value is below the bias

   assign rem_ext    = {1'b0, s1_rem_ff};
   assign six_bits   = 11'(s1_byte_ff) * 11'd6 + 11'd7;
   assign need_six   = 17'd1 + 17'(six_bits >> 3);
   assign need_short = 17'(s1_byte_ff) - 17'd62;
   assign wide_len   = {1'b0, lead_ff, s1_byte_ff} - WIDE_BIAS;

   // six-bit unpacking: up to two codes out of residue and the new byte
   logic [13:0] acc;
   logic [3:0]  bits0, bits1, bits2;
   logic        take1, take2;
   logic [5:0]  code1, code2;
   logic [14:0] keep_mask;

   assign acc   = {residue_ff, s1_byte_ff};
   assign bits0 = {1'b0, rcount_ff} + 4'd8;
   assign take1 = (bits0 >= 4'd6) && (chars_ff != '0);
   assign bits1 = take1 ? bits0 - 4'd6 : bits0;
   assign take2 = take1 && (bits1 >= 4'd6) && (chars_ff > CHARS_W'(1));
   assign bits2 = take2 ? bits1 - 4'd6 : bits1;
   assign code1 = 6'(acc >> (bits0 - 4'd6));
   assign code2 = 6'(acc >> (bits1 - 4'd6));
   assign keep_mask = (15'd1 << bits2) - 15'd1;

   always_comb begin
      phase_in    = phase_ff;
      chars_in    = chars_ff;
      residue_in  = residue_ff;
      rcount_in   = rcount_ff;
      lead_in     = lead_ff;
      out_cnt_in  = 2'd0;
      out_c0_in   = 8'h00;
      out_c1_in   = 8'h00;
      out_done_in = 1'b0;
      out_err_in  = ERR_NONE;

      case (phase_ff)
         PH_HEADER: begin
            if (s1_rem_ff == '0) begin
               out_err_in = ERR_OVERRUN;
            end else if (!byte_mode_ff) begin
               if (s1_byte_ff == '0) begin
                  out_err_in = ERR_EMPTY;
               end else if (s1_byte_ff > 8'(MAX_SIXBIT_CHARS)) begin
                  out_err_in = ERR_SIX_LONG;
               end else if (rem_ext < need_six) begin
                  out_err_in = ERR_OVERRUN;
               end else begin
                  phase_in   = PH_SIXBIT;
                  chars_in   = CHARS_W'(s1_byte_ff);
                  residue_in = '0;
                  rcount_in  = '0;
               end
            end else if (s1_byte_ff[7]) begin
               // two-byte header, length completes with the next byte
               if (s1_rem_ff < 16'd2) begin
                  out_err_in = ERR_OVERRUN;
               end else begin
                  lead_in  = s1_byte_ff;
                  phase_in = PH_WIDE2;
               end
            end else if (s1_byte_ff < SHORT_MIN) begin
               out_err_in = ERR_BAD_LEN;
            end else if (rem_ext < need_short) begin
               out_err_in = ERR_OVERRUN;
            end else begin
               phase_in = PH_RAW;
               chars_in = CHARS_W'(need_short - 17'd1);
            end
         end
         PH_WIDE2: begin
            if (wide_len[16] || (wide_len > 17'(MAX_LONG_CHARS))) begin
               out_err_in = ERR_WIDE_LONG;
            end else if (rem_ext < wide_len + 17'd1) begin
               out_err_in = ERR_OVERRUN;
            end else begin
               phase_in = PH_RAW;
               chars_in = CHARS_W'(wide_len);
               lead_in  = '0;
            end
         end
         PH_SIXBIT: begin
            out_cnt_in = {1'b0, take1} + {1'b0, take2};
            out_c0_in  = take1 ? sym_char(code1) : 8'h00;
            out_c1_in  = take2 ? sym_char(code2) : 8'h00;
            chars_in   = chars_ff - CHARS_W'(out_cnt_in);
            if (chars_in == '0) begin
               out_done_in = 1'b1;
               phase_in    = PH_HEADER;
               residue_in  = '0;
               rcount_in   = '0;
               lead_in     = '0;
            end else begin
               // leftover bits stay here until the next byte
               residue_in = acc[5:0] & keep_mask[5:0];
               rcount_in  = bits2[2:0];
            end
         end
         PH_RAW: begin
            if (chars_ff != '0) begin
               out_cnt_in = 2'd1;
               out_c0_in  = s1_byte_ff;
               chars_in   = chars_ff - CHARS_W'(1);
            end
            if (chars_in == '0) begin
               out_done_in = 1'b1;
               phase_in    = PH_HEADER;
               residue_in  = '0;
               rcount_in   = '0;
               lead_in     = '0;
            end
         end
         default: begin
            phase_in = PH_HEADER;
         end
      endcase

      // any error drops the name and waits for a new header
      if (out_err_in != ERR_NONE) begin
         phase_in   = PH_HEADER;
         chars_in   = '0;
         residue_in = '0;
         rcount_in  = '0;
         lead_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_mode_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_HEADER;
         chars_ff     <= '0;
         residue_ff   <= '0;
         rcount_ff    <= '0;
         lead_ff      <= '0;
      end else begin
         if (csr_write_en) begin
            byte_mode_ff <= csr_write_data;
         end

         // input register
         if (req_bus.ready) begin
            s1_valid_ff <= req_bus.valid;
         end
         if (req_take) begin
            s1_byte_ff <= req_bus.byte_value;
            s1_rem_ff  <= req_bus.remaining_bytes;
         end

         // response register and name state advance together
         if (out_adv) begin
            out_valid_ff <= s1_valid_ff;
         end
         if (s1_fire) begin
            out_cnt_ff  <= out_cnt_in;
            out_c0_ff   <= out_c0_in;
            out_c1_ff   <= out_c1_in;
            out_done_ff <= out_done_in;
            out_err_ff  <= out_err_in;
            phase_ff    <= phase_in;
            chars_ff    <= chars_in;
            residue_ff  <= residue_in;
            rcount_ff   <= rcount_in;
            lead_ff     <= lead_in;
         end
      end
   end

   // an error transaction carries no characters and does not complete a name
   a_err_empty: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_err_ff != ERR_NONE)) |-> ((out_cnt_ff == 2'd0) && !out_done_ff))
      else $error("error response carries characters or done");

   // at most two characters per byte
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_cnt_ff != 2'd3))
      else $error("char_count out of range");

   // between names nothing is left over
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == PH_HEADER) || (phase_ff == PH_WIDE2)) |->
         ((chars_ff == '0) && (residue_ff == '0) && (rcount_ff == '0)))
      else $error("name state not cleared between names");

   // a name in progress always has characters still to come
   a_payload_left: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == PH_SIXBIT) || (phase_ff == PH_RAW)) |-> (chars_ff != '0))
      else $error("payload phase with no characters left");

   // a response appears only after a byte sat in the input register
   a_out_src: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(s1_valid_ff))
      else $error("response without a request");

endmodule

`default_nettype wire
